// ----- design/ntpc_pkg.sv -----
// Shared constants and types for the NTP seconds to calendar converter.
package ntpc_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TZ_HOURS   = 2'd0,
        REG_TZ_MINUTES = 2'd1
    } cfg_reg_t;

    localparam logic [4:0]  TZ_HOURS_RESET   = 5'd5;
    localparam logic [5:0]  TZ_MINUTES_RESET = 6'd30;

    localparam logic [2:0]  MODE_SERVER = 3'd4;
    localparam logic [31:0] EPOCH_2013  = 32'd3565987200;
    localparam logic [11:0] BASE_YEAR   = 12'd2013;

    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;

    // One day is 128 * 675 seconds: the low seven bits pass straight through.
    localparam logic [9:0]  DAY_SHIFTED = 10'd675;

    // Reciprocals: floor(x / d) == (x * M) >> K over each operand's range.
    localparam logic [26:0] RECIP_675  = 27'd101806633;  // K = 36, x < 2^25
    localparam logic [15:0] RECIP_365  = 16'd45965;      // K = 24, x < 2^16
    localparam logic [16:0] RECIP_7    = 17'd74899;      // K = 19, x < 2^16
    localparam logic [16:0] RECIP_3600 = 17'd74566;      // K = 28, x < 86400
    localparam logic [12:0] RECIP_60   = 13'd4370;       // K = 18, x < 3600

    // First day of each month within a 365-day year.
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

endpackage

// ----- design/ntpc_if.sv -----
// Handshake channel interfaces: timestamp input, calendar output, register writes.
interface ntpc_stamp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  header_byte;
    logic [31:0] ntp_seconds;

    modport source (output valid, output header_byte, output ntp_seconds, input ready);
    modport sink   (input valid, input header_byte, input ntp_seconds, output ready);
endinterface

interface ntpc_date_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [2:0]  weekday;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [11:0] year;

    modport source (
        output valid, output status, output weekday, output month,
        output day_of_month, output hour, output minute, output second,
        output year, input ready
    );
    modport sink (
        input valid, input status, input weekday, input month,
        input day_of_month, input hour, input minute, input second,
        input year, output ready
    );
endinterface

interface ntpc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ntpc_pkg::CFG_INDEX_W-1:0] index;
    logic [ntpc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/ntp_seconds_to_calendar.sv -----
// NTP transmit seconds to calendar fields (2013 epoch, 365-day years).
//
// Each transaction on stamp carries an NTP reply header byte and the transmit
// seconds; exactly one transaction on date follows, in order. The seven-stage
// pipeline takes one timestamp every cycle; a stall on date freezes every
// stage, so stamp stays ready while the last stage is empty or its result is
// being taken. A header whose mode is not server yields status 1 with all
// other fields 0. The time-zone registers (hours at index 0, minutes at
// index 1) are always ready and should be written only while the pipeline
// is empty.
module ntp_seconds_to_calendar (
    input  logic           clk,
    input  logic           rst_n,
    ntpc_stamp_if.sink     stamp,
    ntpc_date_if.source    date,
    ntpc_cfg_if.sink       cfg
);

    logic        en;

    logic [4:0]  tz_hours_reg;
    logic [5:0]  tz_minutes_reg;

    // stage 1: local seconds
    logic        v1_reg, err1_reg;
    logic [31:0] local1_reg, local1_next;
    // stage 2: day count
    logic        v2_reg, err2_reg;
    logic [15:0] days2_reg, days2_next;
    logic [24:0] xhi2_reg;
    logic [6:0]  lo2_reg;
    logic [51:0] p675;
    // stage 3: time of day, year quotient
    logic        v3_reg, err3_reg;
    logic [15:0] days3_reg;
    logic [16:0] tod3_reg, tod3_next;
    logic [7:0]  yq3_reg, yq3_next;
    logic [24:0] rem675;
    logic [31:0] p365;
    // stage 4: day of year, week quotient, hour, year
    logic        v4_reg, err4_reg;
    logic [15:0] days4_reg;
    logic [16:0] tod4_reg;
    logic [8:0]  doy4_reg, doy4_next;
    logic [12:0] wq4_reg, wq4_next;
    logic [4:0]  hour4_reg, hour4_next;
    logic [11:0] year4_reg, year4_next;
    logic [15:0] doy_full;
    logic [32:0] p7;
    logic [33:0] p3600;
    // stage 5: weekday, month, day of month, seconds of hour
    logic        v5_reg, err5_reg;
    logic [2:0]  weekday5_reg, weekday5_next;
    logic [3:0]  month5_reg, month5_next;
    logic [4:0]  dom5_reg, dom5_next;
    logic [4:0]  hour5_reg;
    logic [11:0] year5_reg;
    logic [11:0] mos5_reg, mos5_next;
    logic [15:0] wk_full;
    logic [16:0] mos_full;
    logic [8:0]  dom_full;
    // stage 6: minute
    logic        v6_reg, err6_reg;
    logic [2:0]  weekday6_reg;
    logic [3:0]  month6_reg;
    logic [4:0]  dom6_reg;
    logic [4:0]  hour6_reg;
    logic [11:0] year6_reg;
    logic [11:0] mos6_reg;
    logic [5:0]  minute6_reg, minute6_next;
    logic [24:0] p60;
    // stage 7: output
    logic        v7_reg;
    logic        status7_reg;
    logic [2:0]  weekday7_reg;
    logic [3:0]  month7_reg;
    logic [4:0]  dom7_reg;
    logic [4:0]  hour7_reg;
    logic [5:0]  minute7_reg;
    logic [5:0]  second7_reg, second7_next;
    logic [11:0] year7_reg;
    logic [11:0] sec_full;

    assign en          = !v7_reg || date.ready;
    assign stamp.ready = en;
    assign cfg.ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tz_hours_reg   <= ntpc_pkg::TZ_HOURS_RESET;
            tz_minutes_reg <= ntpc_pkg::TZ_MINUTES_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ntpc_pkg::REG_TZ_HOURS:   tz_hours_reg   <= cfg.data[4:0];
                ntpc_pkg::REG_TZ_MINUTES: tz_minutes_reg <= cfg.data[5:0];
                default: ;
            endcase
        end
    end

    // datapath, one stage at a time
    always_comb
    begin
        local1_next = stamp.ntp_seconds - ntpc_pkg::EPOCH_2013
                    + 32'(17'(tz_hours_reg) * 17'(ntpc_pkg::SEC_PER_HOUR))
                    + 32'(12'(tz_minutes_reg) * 12'(ntpc_pkg::SEC_PER_MIN));

        p675       = 52'(local1_reg[31:7]) * 52'(ntpc_pkg::RECIP_675);
        days2_next = p675[51:36];

        rem675    = xhi2_reg - 25'(26'(days2_reg) * 26'(ntpc_pkg::DAY_SHIFTED));
        tod3_next = {rem675[9:0], lo2_reg};
        p365      = 32'(days2_reg) * 32'(ntpc_pkg::RECIP_365);
        yq3_next  = p365[31:24];

        doy_full   = days3_reg - 16'(16'(yq3_reg) * 16'(ntpc_pkg::DAYS_PER_YEAR));
        doy4_next  = doy_full[8:0];
        p7         = 33'(days3_reg) * 33'(ntpc_pkg::RECIP_7);
        wq4_next   = p7[31:19];
        p3600      = 34'(tod3_reg) * 34'(ntpc_pkg::RECIP_3600);
        hour4_next = p3600[32:28];
        year4_next = ntpc_pkg::BASE_YEAR + 12'(yq3_reg);

        wk_full       = days4_reg - 16'(16'(wq4_reg) * 16'(ntpc_pkg::DAYS_PER_WEEK));
        weekday5_next = wk_full[2:0];
        month5_next   = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (doy4_reg >= ntpc_pkg::MONTH_START[i])
                month5_next = 4'(i);
        end
        dom_full  = doy4_reg - ntpc_pkg::MONTH_START[month5_next] + 9'd1;
        dom5_next = dom_full[4:0];
        mos_full  = tod4_reg - 17'(17'(hour4_reg) * 17'(ntpc_pkg::SEC_PER_HOUR));
        mos5_next = mos_full[11:0];

        p60          = 25'(mos5_reg) * 25'(ntpc_pkg::RECIP_60);
        minute6_next = p60[23:18];

        sec_full     = mos6_reg - 12'(12'(minute6_reg) * 12'(ntpc_pkg::SEC_PER_MIN));
        second7_next = sec_full[5:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= stamp.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // payload; hold everything while the output is stalled
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg   <= stamp.header_byte[2:0] != ntpc_pkg::MODE_SERVER;
            local1_reg <= local1_next;

            err2_reg  <= err1_reg;
            days2_reg <= days2_next;
            xhi2_reg  <= local1_reg[31:7];
            lo2_reg   <= local1_reg[6:0];

            err3_reg  <= err2_reg;
            days3_reg <= days2_reg;
            tod3_reg  <= tod3_next;
            yq3_reg   <= yq3_next;

            err4_reg  <= err3_reg;
            days4_reg <= days3_reg;
            tod4_reg  <= tod3_reg;
            doy4_reg  <= doy4_next;
            wq4_reg   <= wq4_next;
            hour4_reg <= hour4_next;
            year4_reg <= year4_next;

            err5_reg     <= err4_reg;
            weekday5_reg <= weekday5_next;
            month5_reg   <= month5_next;
            dom5_reg     <= dom5_next;
            hour5_reg    <= hour4_reg;
            year5_reg    <= year4_reg;
            mos5_reg     <= mos5_next;

            err6_reg     <= err5_reg;
            weekday6_reg <= weekday5_reg;
            month6_reg   <= month5_reg;
            dom6_reg     <= dom5_reg;
            hour6_reg    <= hour5_reg;
            year6_reg    <= year5_reg;
            mos6_reg     <= mos5_reg;
            minute6_reg  <= minute6_next;

            // zero every field of a rejected header
            status7_reg  <= err6_reg;
            weekday7_reg <= err6_reg ? 3'd0  : weekday6_reg;
            month7_reg   <= err6_reg ? 4'd0  : month6_reg;
            dom7_reg     <= err6_reg ? 5'd0  : dom6_reg;
            hour7_reg    <= err6_reg ? 5'd0  : hour6_reg;
            minute7_reg  <= err6_reg ? 6'd0  : minute6_reg;
            second7_reg  <= err6_reg ? 6'd0  : second7_next;
            year7_reg    <= err6_reg ? 12'd0 : year6_reg;
        end
    end

    assign date.valid        = v7_reg;
    assign date.status       = status7_reg;
    assign date.weekday      = weekday7_reg;
    assign date.month        = month7_reg;
    assign date.day_of_month = dom7_reg;
    assign date.hour         = hour7_reg;
    assign date.minute       = minute7_reg;
    assign date.second       = second7_reg;
    assign date.year         = year7_reg;

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        date.valid && date.status |->
            date.weekday == 3'd0 && date.month == 4'd0 && date.day_of_month == 5'd0 &&
            date.hour == 5'd0 && date.minute == 6'd0 && date.second == 6'd0 &&
            date.year == 12'd0)
        else $error("rejected header produced nonzero fields");

    a_ok_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        date.valid && !date.status |->
            date.weekday <= 3'd6 && date.month <= 4'd11 && date.day_of_month >= 5'd1 &&
            date.hour <= 5'd23 && date.minute <= 6'd59 && date.second <= 6'd59 &&
            date.year >= ntpc_pkg::BASE_YEAR)
        else $error("calendar field out of range");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg}))
        else $error("pipeline valids moved during a stall");

endmodule
